// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// cons must hold in the same cycle as ante
`define STFF_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// cons must hold in the cycle after ante
`define STFF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define STFF_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define STFF_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== rtl/core/stff_pkg.sv =====
// ----------------------------------------------------------------------------
// stff_pkg
// Types, constants and microprogram of the surface tension face flux block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package stff_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int SIGMA_W   = 31;
  localparam int ACC_W     = 4 * DATA_W;
  localparam int STEP_W    = 6;
  localparam int CNT_W     = 6;

  // root unit: one result bit per cycle
  localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(DATA_W - 1);
  // divider: overflow check, DATA_W bit steps, clamp
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DATA_W + 1);

  localparam logic [1:0] MODE_INNER   = 2'd0;
  localparam logic [1:0] MODE_NONREFL = 2'd1;
  localparam logic [1:0] MODE_WALL    = 2'd2;
  localparam logic       SIDE_LEFT    = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_ACC, ST_SQRT, ST_DIV, ST_EXEC, ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    K_MAC, K_SQRT, K_DIV, K_CHKN, K_SAVE_T, K_SAVE_S, K_END
  } kind_t;

  typedef enum logic [4:0] {
    OPD_GL0, OPD_GL1, OPD_GL2, OPD_GR0, OPD_GR1, OPD_GR2,
    OPD_A0, OPD_A1, OPD_A2, OPD_A3, OPD_A4, OPD_A5,
    OPD_SIG, OPD_TLO, OPD_THI, OPD_SLO, OPD_SHI
  } opnd_t;

  typedef enum logic [1:0] {SH_0, SH_32, SH_64} shift_t;

  typedef enum logic [1:0] {NEG_ALWAYS, NEG_A3A4, NEG_A3A5, NEG_E} neg_t;

  typedef enum logic [2:0] {
    ACT_NONE, ACT_HOLD, ACT_LOAD_PAIR, ACT_LOAD_SELF, ACT_ZERO
  } act_t;

  typedef struct packed {
    kind_t      kind;
    opnd_t      opa;
    opnd_t      opb;
    shift_t     sh;
    logic       clr;        // start a fresh sum
    logic       sgn;        // honor operand signs
    logic       dst_right;  // root goes to right-side norm
    logic       k32;        // divisor scaled by 2^(2F) instead of 2^F
    logic [1:0] slot;
    neg_t       neg;
    logic       stop_wall;
  } uword_t;

  typedef struct packed {
    state_t           st;
    uword_t           uw;
    logic [CNT_W-1:0] cnt;
    act_t             act;
  } ctl_t;

  function automatic uword_t uw_base(kind_t k);
    uword_t u;
    u      = '0;
    u.kind = k;
    return u;
  endfunction

  function automatic uword_t uw_mac(opnd_t a, opnd_t b, shift_t sh, logic clr, logic sgn);
    uword_t u;
    u     = uw_base(K_MAC);
    u.opa = a;
    u.opb = b;
    u.sh  = sh;
    u.clr = clr;
    u.sgn = sgn;
    return u;
  endfunction

  function automatic uword_t uw_sqrt(logic right);
    uword_t u;
    u           = uw_base(K_SQRT);
    u.dst_right = right;
    return u;
  endfunction

  function automatic uword_t uw_div(logic k32, logic [1:0] slot, neg_t n, logic stop);
    uword_t u;
    u           = uw_base(K_DIV);
    u.k32       = k32;
    u.slot      = slot;
    u.neg       = n;
    u.stop_wall = stop;
    return u;
  endfunction

  // Microprogram: norms, zero check, then the four flux terms.
  function automatic uword_t ucode(logic [STEP_W-1:0] step);
    uword_t u;
    case (step)
      6'd0:  u = uw_mac(OPD_GL0, OPD_GL0, SH_0, 1'b1, 1'b0);
      6'd1:  u = uw_mac(OPD_GL1, OPD_GL1, SH_0, 1'b0, 1'b0);
      6'd2:  u = uw_mac(OPD_GL2, OPD_GL2, SH_0, 1'b0, 1'b0);
      6'd3:  u = uw_sqrt(1'b0);
      6'd4:  u = uw_mac(OPD_GR0, OPD_GR0, SH_0, 1'b1, 1'b0);
      6'd5:  u = uw_mac(OPD_GR1, OPD_GR1, SH_0, 1'b0, 1'b0);
      6'd6:  u = uw_mac(OPD_GR2, OPD_GR2, SH_0, 1'b0, 1'b0);
      6'd7:  u = uw_sqrt(1'b1);
      6'd8:  u = uw_base(K_CHKN);
      6'd9:  u = uw_mac(OPD_A4, OPD_A4, SH_0, 1'b1, 1'b0);
      6'd10: u = uw_mac(OPD_A5, OPD_A5, SH_0, 1'b0, 1'b0);
      6'd11: u = uw_base(K_SAVE_T);
      6'd12: u = uw_mac(OPD_SIG, OPD_TLO, SH_0, 1'b1, 1'b0);
      6'd13: u = uw_mac(OPD_SIG, OPD_THI, SH_32, 1'b0, 1'b0);
      6'd14: u = uw_div(1'b0, 2'd0, NEG_ALWAYS, 1'b1);
      6'd15: u = uw_mac(OPD_SIG, OPD_A3, SH_0, 1'b1, 1'b0);
      6'd16: u = uw_base(K_SAVE_S);
      6'd17: u = uw_mac(OPD_SLO, OPD_A4, SH_0, 1'b1, 1'b0);
      6'd18: u = uw_mac(OPD_SHI, OPD_A4, SH_32, 1'b0, 1'b0);
      6'd19: u = uw_div(1'b0, 2'd1, NEG_A3A4, 1'b0);
      6'd20: u = uw_mac(OPD_SLO, OPD_A5, SH_0, 1'b1, 1'b0);
      6'd21: u = uw_mac(OPD_SHI, OPD_A5, SH_32, 1'b0, 1'b0);
      6'd22: u = uw_div(1'b0, 2'd2, NEG_A3A5, 1'b0);
      6'd23: u = uw_mac(OPD_A3, OPD_A0, SH_0, 1'b1, 1'b1);
      6'd24: u = uw_mac(OPD_A4, OPD_A1, SH_0, 1'b0, 1'b1);
      6'd25: u = uw_mac(OPD_A5, OPD_A2, SH_0, 1'b0, 1'b1);
      6'd26: u = uw_base(K_SAVE_T);
      6'd27: u = uw_mac(OPD_SLO, OPD_TLO, SH_0, 1'b1, 1'b0);
      6'd28: u = uw_mac(OPD_SLO, OPD_THI, SH_32, 1'b0, 1'b0);
      6'd29: u = uw_mac(OPD_SHI, OPD_TLO, SH_32, 1'b0, 1'b0);
      6'd30: u = uw_mac(OPD_SHI, OPD_THI, SH_64, 1'b0, 1'b0);
      6'd31: u = uw_div(1'b1, 2'd3, NEG_E, 1'b0);
      default: u = uw_base(K_END);
    endcase
    return u;
  endfunction

  function automatic state_t state_of(uword_t u);
    state_t s;
    case (u.kind)
      K_MAC:   s = ST_MUL;
      K_SQRT:  s = ST_SQRT;
      K_DIV:   s = ST_DIV;
      K_END:   s = ST_OUT;
      default: s = ST_EXEC;
    endcase
    return s;
  endfunction

  // {sign, magnitude}
  function automatic logic [DATA_W:0] smag(logic signed [DATA_W-1:0] v);
    logic [DATA_W-1:0] m;
    m = v[DATA_W-1] ? DATA_W'(-v) : DATA_W'(v);
    return {v[DATA_W-1], m};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/stff_mul.sv =====
// ----------------------------------------------------------------------------
// stff_mul
// Shared unsigned 32x32 multiplier with registered product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stff_mul (
  input  logic                            clk,
  input  logic                            en,
  input  logic [stff_pkg::DATA_W-1:0]     a,
  input  logic [stff_pkg::DATA_W-1:0]     b,
  output logic [2*stff_pkg::DATA_W-1:0]   p
);

  logic [2*stff_pkg::DATA_W-1:0] p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= (2*stff_pkg::DATA_W)'(a) * (2*stff_pkg::DATA_W)'(b);
    end
  end

  assign p = p_r;

endmodule

`default_nettype wire

// ===== rtl/core/stff_ctrl.sv =====
// ----------------------------------------------------------------------------
// stff_ctrl
// Sequencer: accepts items, steps the microprogram, times root and divide.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stff_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_mode,
  input  logic              in_side,
  input  logic              out_stall,
  input  logic              n_zero,
  output stff_pkg::ctl_t    ctl,
  output logic              in_stall,
  output logic              out_valid
);

  stff_pkg::state_t                   st_r, st_nxt;
  logic [stff_pkg::STEP_W-1:0]        step_r, step_nxt;
  logic [stff_pkg::CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                               pend_r, pend_nxt;
  logic                               wall_r, wall_nxt;
  stff_pkg::act_t                     act;
  stff_pkg::uword_t                   uw, uw_next;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= stff_pkg::ST_IDLE;
      step_r <= '0;
      cnt_r  <= '0;
      pend_r <= 1'b0;
      wall_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      step_r <= step_nxt;
      cnt_r  <= cnt_nxt;
      pend_r <= pend_nxt;
      wall_r <= wall_nxt;
    end
  end

  always_comb begin
    uw       = stff_pkg::ucode(step_r);
    uw_next  = stff_pkg::ucode(step_r + stff_pkg::STEP_W'(1));
    st_nxt   = st_r;
    step_nxt = step_r;
    cnt_nxt  = cnt_r;
    pend_nxt = pend_r;
    wall_nxt = wall_r;
    act      = stff_pkg::ACT_NONE;
    case (st_r)
      stff_pkg::ST_IDLE: begin
        if (in_valid) begin
          step_nxt = '0;
          cnt_nxt  = '0;
          case (in_mode)
            stff_pkg::MODE_INNER: begin
              if (in_side == stff_pkg::SIDE_LEFT) begin
                act      = stff_pkg::ACT_HOLD;
                pend_nxt = 1'b1;
              end else if (pend_r) begin
                act      = stff_pkg::ACT_LOAD_PAIR;
                pend_nxt = 1'b0;
                wall_nxt = 1'b0;
                st_nxt   = stff_pkg::state_of(stff_pkg::ucode('0));
              end
            end
            stff_pkg::MODE_NONREFL: begin
              act      = stff_pkg::ACT_LOAD_SELF;
              wall_nxt = 1'b0;
              st_nxt   = stff_pkg::state_of(stff_pkg::ucode('0));
            end
            stff_pkg::MODE_WALL: begin
              act      = stff_pkg::ACT_LOAD_SELF;
              wall_nxt = 1'b1;
              st_nxt   = stff_pkg::state_of(stff_pkg::ucode('0));
            end
            default: begin
              act    = stff_pkg::ACT_ZERO;
              st_nxt = stff_pkg::ST_OUT;
            end
          endcase
        end
      end
      stff_pkg::ST_MUL: st_nxt = stff_pkg::ST_ACC;
      stff_pkg::ST_ACC: begin
        step_nxt = step_r + stff_pkg::STEP_W'(1);
        st_nxt   = stff_pkg::state_of(uw_next);
      end
      stff_pkg::ST_SQRT: begin
        if (cnt_r == stff_pkg::SQRT_LAST) begin
          cnt_nxt  = '0;
          step_nxt = step_r + stff_pkg::STEP_W'(1);
          st_nxt   = stff_pkg::state_of(uw_next);
        end else begin
          cnt_nxt = cnt_r + stff_pkg::CNT_W'(1);
        end
      end
      stff_pkg::ST_DIV: begin
        if (cnt_r == stff_pkg::DIV_LAST) begin
          cnt_nxt = '0;
          if (uw.stop_wall && wall_r) begin
            st_nxt = stff_pkg::ST_OUT;
          end else begin
            step_nxt = step_r + stff_pkg::STEP_W'(1);
            st_nxt   = stff_pkg::state_of(uw_next);
          end
        end else begin
          cnt_nxt = cnt_r + stff_pkg::CNT_W'(1);
        end
      end
      stff_pkg::ST_EXEC: begin
        if (uw.kind == stff_pkg::K_CHKN && n_zero) begin
          st_nxt = stff_pkg::ST_OUT;
        end else begin
          step_nxt = step_r + stff_pkg::STEP_W'(1);
          st_nxt   = stff_pkg::state_of(uw_next);
        end
      end
      stff_pkg::ST_OUT: begin
        if (!out_stall) st_nxt = stff_pkg::ST_IDLE;
      end
      default: st_nxt = stff_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl.st  = st_r;
    ctl.uw  = uw;
    ctl.cnt = cnt_r;
    ctl.act = act;
  end

  assign in_stall  = (st_r != stff_pkg::ST_IDLE);
  assign out_valid = (st_r == stff_pkg::ST_OUT);

endmodule

`default_nettype wire

// ===== rtl/core/stff_dp.sv =====
// ----------------------------------------------------------------------------
// stff_dp
// Datapath: operand store, shared multiply-accumulate, root and divide units.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stff_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  stff_pkg::ctl_t                        ctl,
  input  logic                                  cfg_wr_en,
  input  logic [stff_pkg::SIGMA_W-1:0]          cfg_wr_data,
  input  logic signed [stff_pkg::DATA_W-1:0]    vel_normal,
  input  logic signed [stff_pkg::DATA_W-1:0]    vel_tangent,
  input  logic signed [stff_pkg::DATA_W-1:0]    vel_binormal,
  input  logic signed [stff_pkg::DATA_W-1:0]    grad_normal,
  input  logic signed [stff_pkg::DATA_W-1:0]    grad_tangent,
  input  logic signed [stff_pkg::DATA_W-1:0]    grad_binormal,
  output logic signed [stff_pkg::DATA_W-1:0]    mom_normal,
  output logic signed [stff_pkg::DATA_W-1:0]    mom_tangent,
  output logic signed [stff_pkg::DATA_W-1:0]    mom_binormal,
  output logic signed [stff_pkg::DATA_W-1:0]    energy_flux,
  output logic                                  saturated,
  output logic                                  n_zero
);

  localparam int W  = stff_pkg::DATA_W;
  localparam int AW = stff_pkg::ACC_W;

  logic [stff_pkg::SIGMA_W-1:0] sigma_r;
  logic signed [W-1:0]   held_r [6];
  logic signed [W-1:0]   cur    [6];
  logic signed [W-1:0]   lsrc   [6];
  logic [W:0]            sum33  [6];
  logic signed [W-1:0]   avg    [6];
  logic signed [W-1:0]   g_r    [6];
  logic signed [W-1:0]   a_r    [6];
  logic [W:0]            gm     [6];
  logic [W:0]            am     [6];
  logic [W:0]            opa_v, opb_v;
  logic [2*W-1:0]        prod;
  logic                  load;

  logic [AW-1:0]         acc_r, term, acc_sum, acc_mag;
  logic [6:0]            shamt;
  logic                  sgn_r;

  logic [2*W-1:0]        rt_r, rcur, bitv, r_nxt, x_nxt;
  logic [2*W:0]          trial;
  logic                  take;
  logic [W-1:0]          nl_r, nr_r, n_val;
  logic [W:0]            n_sum;

  logic [2*W-1:0]        t_r;
  logic [2*W-2:0]        s_r;
  logic                  esign_r;

  logic [2*W-1:0]        dvsr, rem_r, rem_nxt;
  logic [2*W:0]          rem2;
  logic                  ge, ovf, ovf_r, neg, sat_now;
  logic [W-1:0]          q_r, lim, clip, resv;
  logic signed [W-1:0]   res_r [4];
  logic                  sat_r;

  function automatic logic [W:0] sel_op(stff_pkg::opnd_t s, logic [W:0] gmv [6],
                                        logic [W:0] amv [6],
                                        logic [stff_pkg::SIGMA_W-1:0] sg,
                                        logic [2*W-1:0] tv, logic [2*W-2:0] sv);
    logic [W:0] r;
    case (s)
      stff_pkg::OPD_GL0: r = gmv[0];
      stff_pkg::OPD_GL1: r = gmv[1];
      stff_pkg::OPD_GL2: r = gmv[2];
      stff_pkg::OPD_GR0: r = gmv[3];
      stff_pkg::OPD_GR1: r = gmv[4];
      stff_pkg::OPD_GR2: r = gmv[5];
      stff_pkg::OPD_A0:  r = amv[0];
      stff_pkg::OPD_A1:  r = amv[1];
      stff_pkg::OPD_A2:  r = amv[2];
      stff_pkg::OPD_A3:  r = amv[3];
      stff_pkg::OPD_A4:  r = amv[4];
      stff_pkg::OPD_A5:  r = amv[5];
      stff_pkg::OPD_SIG: r = (W+1)'(sg);
      stff_pkg::OPD_TLO: r = {1'b0, tv[W-1:0]};
      stff_pkg::OPD_THI: r = {1'b0, tv[2*W-1:W]};
      stff_pkg::OPD_SLO: r = {1'b0, sv[W-1:0]};
      stff_pkg::OPD_SHI: r = (W+1)'(sv[2*W-2:W]);
      default:           r = '0;
    endcase
    return r;
  endfunction

  // ---- operand capture ----
  always_comb begin
    cur[0] = vel_normal;
    cur[1] = vel_tangent;
    cur[2] = vel_binormal;
    cur[3] = grad_normal;
    cur[4] = grad_tangent;
    cur[5] = grad_binormal;
    for (int i = 0; i < 6; i++) begin
      lsrc[i]  = (ctl.act == stff_pkg::ACT_LOAD_PAIR) ? held_r[i] : cur[i];
      // floor of the side average
      sum33[i] = {lsrc[i][W-1], lsrc[i]} + {cur[i][W-1], cur[i]};
      avg[i]   = sum33[i][W:1];
      gm[i]    = stff_pkg::smag(g_r[i]);
      am[i]    = stff_pkg::smag(a_r[i]);
    end
    load = (ctl.st == stff_pkg::ST_IDLE) &&
           (ctl.act == stff_pkg::ACT_LOAD_PAIR || ctl.act == stff_pkg::ACT_LOAD_SELF);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sigma_r <= '0;
      for (int i = 0; i < 6; i++) held_r[i] <= '0;
    end else begin
      if (cfg_wr_en) sigma_r <= cfg_wr_data;
      if (ctl.st == stff_pkg::ST_IDLE && ctl.act == stff_pkg::ACT_HOLD) begin
        for (int i = 0; i < 6; i++) held_r[i] <= cur[i];
      end
    end
  end

  // ---- shared multiply-accumulate ----
  assign opa_v = sel_op(ctl.uw.opa, gm, am, sigma_r, t_r, s_r);
  assign opb_v = sel_op(ctl.uw.opb, gm, am, sigma_r, t_r, s_r);

  stff_mul u_mul (
    .clk (clk),
    .en  (ctl.st == stff_pkg::ST_MUL),
    .a   (opa_v[W-1:0]),
    .b   (opb_v[W-1:0]),
    .p   (prod)
  );

  always_comb begin
    case (ctl.uw.sh)
      stff_pkg::SH_32: shamt = 7'(W);
      stff_pkg::SH_64: shamt = 7'(2 * W);
      default:         shamt = '0;
    endcase
    term = AW'(prod) << shamt;
    if (ctl.uw.sgn && sgn_r) term = AW'(-term);
    acc_sum = (ctl.uw.clr ? '0 : acc_r) + term;
    acc_mag = acc_r[AW-1] ? AW'(-acc_r) : acc_r;
  end

  // ---- root unit, one result bit per cycle ----
  always_comb begin
    bitv  = (2*W)'(1) << {~ctl.cnt[4:0], 1'b0};
    rcur  = (ctl.cnt == '0) ? '0 : rt_r;
    trial = {1'b0, rcur} + {1'b0, bitv};
    take  = {1'b0, acc_r[2*W-1:0]} >= trial;
    x_nxt = acc_r[2*W-1:0] - trial[2*W-1:0];
    r_nxt = take ? (rcur >> 1) + bitv : rcur >> 1;
    n_sum = (W+1)'(nl_r >> 1) + (W+1)'(nr_r >> 1) + (W+1)'(nl_r[0] & nr_r[0]);
    n_val = n_sum[W-1:0];
  end

  assign n_zero = (n_val == '0);

  // ---- restoring divider by n scaled to the fixed point ----
  always_comb begin
    dvsr = (2*W)'(n_val) << (ctl.uw.k32 ? 2 * stff_pkg::FRAC_BITS : stff_pkg::FRAC_BITS);
    ovf  = acc_r[AW-1:W] >= (AW-W)'(dvsr);
    rem2 = {rem_r, acc_r[W-1]};
    ge   = rem2 >= {1'b0, dvsr};
    rem_nxt = ge ? (2*W)'(rem2 - {1'b0, dvsr}) : rem2[2*W-1:0];
    case (ctl.uw.neg)
      stff_pkg::NEG_A3A4: neg = a_r[3][W-1] ^ a_r[4][W-1];
      stff_pkg::NEG_A3A5: neg = a_r[3][W-1] ^ a_r[5][W-1];
      stff_pkg::NEG_E:    neg = esign_r ^ a_r[3][W-1];
      default:            neg = 1'b1;
    endcase
    lim     = {1'b0, {(W-1){1'b1}}} + W'(neg);
    sat_now = ovf_r | (q_r > lim);
    clip    = sat_now ? lim : q_r;
    resv    = neg ? W'(-clip) : clip;
  end

  always_ff @(posedge clk) begin
    case (ctl.st)
      stff_pkg::ST_IDLE: begin
        if (load) begin
          for (int i = 0; i < 3; i++) begin
            g_r[i]     <= lsrc[i+3];
            g_r[i+3]   <= cur[i+3];
          end
          for (int i = 0; i < 6; i++) a_r[i] <= avg[i];
        end
        if (load || ctl.act == stff_pkg::ACT_ZERO) begin
          for (int i = 0; i < 4; i++) res_r[i] <= '0;
          sat_r <= 1'b0;
        end
      end
      stff_pkg::ST_MUL: sgn_r <= opa_v[W] ^ opb_v[W];
      stff_pkg::ST_ACC: acc_r <= acc_sum;
      stff_pkg::ST_SQRT: begin
        if (take) acc_r[2*W-1:0] <= x_nxt;
        rt_r <= r_nxt;
        if (ctl.cnt == stff_pkg::SQRT_LAST) begin
          if (ctl.uw.dst_right) nr_r <= r_nxt[W-1:0];
          else                  nl_r <= r_nxt[W-1:0];
        end
      end
      stff_pkg::ST_DIV: begin
        if (ctl.cnt == '0) begin
          ovf_r <= ovf;
          rem_r <= acc_r[3*W-1:W];
        end else if (ctl.cnt == stff_pkg::DIV_LAST) begin
          res_r[ctl.uw.slot] <= resv;
          sat_r              <= sat_r | sat_now;
        end else begin
          rem_r <= rem_nxt;
          q_r   <= {q_r[W-2:0], ge};
          acc_r <= acc_r << 1;
        end
      end
      stff_pkg::ST_EXEC: begin
        case (ctl.uw.kind)
          stff_pkg::K_SAVE_T: begin
            t_r     <= acc_mag[2*W-1:0];
            esign_r <= acc_r[AW-1];
          end
          stff_pkg::K_SAVE_S: s_r <= acc_r[2*W-2:0];
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign mom_normal   = res_r[0];
  assign mom_tangent  = res_r[1];
  assign mom_binormal = res_r[2];
  assign energy_flux  = res_r[3];
  assign saturated    = sat_r;

endmodule

`default_nettype wire

// ===== rtl/core/surface_tension_face_flux.sv =====
// ----------------------------------------------------------------------------
// surface_tension_face_flux
// Capillary momentum and energy flux across one cell face, Q16.16.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------
//  cfg      | cfg_wr_en            | cfg_wr_data (sigma, unsigned Q15.16)
//  in       | in_valid / in_stall  | mode, side, vel_*, grad_* (signed)
//  out      | out_valid / out_stall| mom_*, energy_flux, saturated
//
// One face at a time. Inner and nonreflecting faces run from accept to result
// through two square roots, four restoring divides and 22 multiply-accumulate
// steps on the one shared 32x32 multiplier.
// Wall faces end after the first divide, zero-norm faces after the roots.
// Left inner items and stray right items are absorbed without leaving idle.
// in_stall is high from accept until the result transaction completes.
// Synchronous active-low reset clears sigma, the held side and the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module surface_tension_face_flux (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [stff_pkg::SIGMA_W-1:0]          cfg_wr_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [1:0]                            in_mode,
  input  logic                                  in_side,
  input  logic signed [stff_pkg::DATA_W-1:0]    in_vel_normal,
  input  logic signed [stff_pkg::DATA_W-1:0]    in_vel_tangent,
  input  logic signed [stff_pkg::DATA_W-1:0]    in_vel_binormal,
  input  logic signed [stff_pkg::DATA_W-1:0]    in_grad_normal,
  input  logic signed [stff_pkg::DATA_W-1:0]    in_grad_tangent,
  input  logic signed [stff_pkg::DATA_W-1:0]    in_grad_binormal,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [stff_pkg::DATA_W-1:0]    out_mom_normal,
  output logic signed [stff_pkg::DATA_W-1:0]    out_mom_tangent,
  output logic signed [stff_pkg::DATA_W-1:0]    out_mom_binormal,
  output logic signed [stff_pkg::DATA_W-1:0]    out_energy_flux,
  output logic                                  out_saturated
);

  stff_pkg::ctl_t ctl;
  logic           n_zero;

  stff_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_mode   (in_mode),
    .in_side   (in_side),
    .out_stall (out_stall),
    .n_zero    (n_zero),
    .ctl       (ctl),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  stff_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .vel_normal    (in_vel_normal),
    .vel_tangent   (in_vel_tangent),
    .vel_binormal  (in_vel_binormal),
    .grad_normal   (in_grad_normal),
    .grad_tangent  (in_grad_tangent),
    .grad_binormal (in_grad_binormal),
    .mom_normal    (out_mom_normal),
    .mom_tangent   (out_mom_tangent),
    .mom_binormal  (out_mom_binormal),
    .energy_flux   (out_energy_flux),
    .saturated     (out_saturated),
    .n_zero        (n_zero)
  );

  // a waiting result keeps the input side closed
  `STFF_ASSERT_IMPLIES(a_one_in_flight, clk, rst_n, out_valid, in_stall)
  // a delivered result is not shown twice
  `STFF_ASSERT_NEXT(a_out_retire, clk, rst_n, out_valid && !out_stall, !out_valid)
  // normal momentum is never positive
  `STFF_ASSERT_IMPLIES(a_mom_normal_sign, clk, rst_n,
                       out_valid && !out_mom_normal[stff_pkg::DATA_W-1], out_mom_normal == '0)
  // divider count never runs past its clamp cycle
  `STFF_ASSERT_IMPLIES(a_div_count, clk, rst_n, ctl.st == stff_pkg::ST_DIV,
                       ctl.cnt <= stff_pkg::DIV_LAST)

endmodule

`default_nettype wire
